[rtl/core/lds_pkg.sv]
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, widths and helpers for the longest divisible-sum run block.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int MAX_DIVISOR = 256;
  localparam int MAX_LENGTH  = 65535;

  localparam int VAL_W = 32;                          // input element width
  localparam int CFG_W = 9;                           // divisor register width
  localparam int OUT_W = 16;                          // best_length width
  localparam int REM_W = $clog2(MAX_DIVISOR);         // remainder width
  localparam int DIV_W = $clog2(MAX_DIVISOR + 1);     // effective divisor width
  localparam int POS_W = $clog2(MAX_LENGTH + 1);      // position width
  localparam int STEPS = VAL_W - 1;                   // Horner steps after sign
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int OUT_MAX = (1 << OUT_W) - 1;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StUpd
  } lds_state_e;

  // Table access issued by the sequencer
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             clr;
    logic [REM_W-1:0] addr;
    logic [POS_W-1:0] wdata;
  } tbl_ctrl_t;

  // Zero reads as one, values above the table size saturate
  function automatic logic [DIV_W-1:0] eff_div(input logic [CFG_W-1:0] cfg);
    logic [DIV_W-1:0] res;
    if (cfg == '0) begin
      res = DIV_W'(1);
    end else if (32'(cfg) > 32'(MAX_DIVISOR)) begin
      res = DIV_W'(MAX_DIVISOR);
    end else begin
      res = DIV_W'(cfg);
    end
    return res;
  endfunction

  // One Horner step: (2r + b) mod d, with r < d
  function automatic logic [REM_W-1:0] horner(input logic [REM_W-1:0] r,
                                              input logic             b,
                                              input logic [DIV_W-1:0] d);
    logic [REM_W:0] t;
    logic [REM_W:0] dx;
    t  = {r, b};
    dx = (REM_W+1)'(d);
    if (t >= dx) begin
      t = t - dx;
    end
    return REM_W'(t);
  endfunction

  function automatic logic [OUT_W-1:0] sat_len(input logic [POS_W-1:0] v);
    logic [OUT_W-1:0] res;
    if (32'(v) > 32'(OUT_MAX)) begin
      res = '1;
    end else begin
      res = OUT_W'(v);
    end
    return res;
  endfunction

endpackage

[rtl/core/lds_mod_unit.sv]
// ----------------------------------------------------------------------------
// lds_mod_unit
// Bit-serial reduction of (remainder + signed value) modulo the divisor.
// ----------------------------------------------------------------------------
module lds_mod_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lds_pkg::VAL_W-1:0] value_i,
  input  logic [lds_pkg::REM_W-1:0] rem_in_i,
  input  logic [lds_pkg::DIV_W-1:0] div_i,
  output logic                      done_o,
  output logic [lds_pkg::REM_W-1:0] rem_o
);

  logic                      busy_q;
  logic [lds_pkg::CNT_W-1:0] cnt_q;
  logic [lds_pkg::VAL_W-2:0] sv_q;   // value bits below the sign, MSB first
  logic [lds_pkg::VAL_W-2:0] sr_q;   // old remainder, zero extended
  logic [lds_pkg::REM_W-1:0] av_q;
  logic [lds_pkg::REM_W-1:0] ar_q;
  logic [lds_pkg::DIV_W-1:0] d_q;
  logic                      done_q;
  logic [lds_pkg::REM_W-1:0] rem_q;
  logic [lds_pkg::REM_W:0]   sum;

  assign sum = (lds_pkg::REM_W+1)'(av_q) + (lds_pkg::REM_W+1)'(ar_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= lds_pkg::CNT_W'(lds_pkg::STEPS);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sv_q <= value_i[lds_pkg::VAL_W-2:0];
      sr_q <= (lds_pkg::VAL_W-1)'(rem_in_i);
      d_q  <= div_i;
      ar_q <= '0;
      // sign bit has weight -2^31: start from -1 mod d
      av_q <= value_i[lds_pkg::VAL_W-1] ? lds_pkg::REM_W'(div_i - 1'b1) : '0;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        av_q <= lds_pkg::horner(av_q, sv_q[lds_pkg::VAL_W-2], d_q);
        ar_q <= lds_pkg::horner(ar_q, sr_q[lds_pkg::VAL_W-2], d_q);
        sv_q <= {sv_q[lds_pkg::VAL_W-3:0], 1'b0};
        sr_q <= {sr_q[lds_pkg::VAL_W-3:0], 1'b0};
      end else begin
        rem_q <= (sum >= (lds_pkg::REM_W+1)'(d_q))
                 ? lds_pkg::REM_W'(sum - (lds_pkg::REM_W+1)'(d_q))
                 : lds_pkg::REM_W'(sum);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/lds_table.sv]
// ----------------------------------------------------------------------------
// lds_table
// First-seen position memory with per-remainder seen flags.
// ----------------------------------------------------------------------------
module lds_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lds_pkg::tbl_ctrl_t        ctrl_i,
  output logic                      seen_o,
  output logic [lds_pkg::POS_W-1:0] first_o
);

  logic [lds_pkg::MAX_DIVISOR-1:0] flags_q;
  logic [lds_pkg::POS_W-1:0]       mem [lds_pkg::MAX_DIVISOR];
  logic [lds_pkg::POS_W-1:0]       rdata_q;
  logic                            seen_q;
  logic                            zero_q;

  // remainder zero is always seen, at position zero; its entry is never written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= lds_pkg::MAX_DIVISOR'(1);
    end else if (ctrl_i.clr) begin
      flags_q <= lds_pkg::MAX_DIVISOR'(1);
    end else if (ctrl_i.wr) begin
      flags_q[ctrl_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[ctrl_i.addr] <= ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem[ctrl_i.addr];
      seen_q  <= flags_q[ctrl_i.addr];
      zero_q  <= (ctrl_i.addr == '0);
    end
  end

  assign seen_o  = seen_q;
  assign first_o = zero_q ? '0 : rdata_q;

endmodule

[rtl/core/longest_divisible_sum_subarray.sv]
// ----------------------------------------------------------------------------
// longest_divisible_sum_subarray
// Streams signed elements and reports the longest run whose sum divides by
// the configured divisor.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one element per transaction: tdata = value (32 bits,
//   signed), tlast marks the last element of a sequence. m_axis returns one
//   result per element: tdata = best_length (16 bits), tlast = done_res,
//   tuser = overflow. cfg_* writes the 9-bit divisor (reset 1, zero acts as
//   one, values above 256 act as 256); write it only while the block is idle.
//   An element goes from its accepting edge to a valid result through
//   one-bit Horner reduction in lds_mod_unit, one final add, one table
//   read and one update. The next element is accepted in the cycle after
//   the update, so only one element is in flight at a time.
//   Reset clears all sequence state and sets the divisor to one; the seen
//   flags reset at once, no clearing pass is needed. A result waiting on a
//   stalled receiver sits in the output register; the next element is still
//   accepted and computed, and its update waits until the output register
//   is free. A result with done_res set clears the table and counters for
//   the next sequence.
// ----------------------------------------------------------------------------
module longest_divisible_sum_subarray (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lds_pkg::CFG_W-1:0] cfg_data_i,     // divisor
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [lds_pkg::VAL_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic                      s_axis_tlast,   // last
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [lds_pkg::OUT_W-1:0] m_axis_tdata,   // [15:0] best_length
  output logic                      m_axis_tlast,   // done_res
  output logic                      m_axis_tuser    // [0] overflow
);

  lds_pkg::lds_state_e       state_q, state_d;
  logic [lds_pkg::CFG_W-1:0] div_q;
  logic                      last_q;
  logic [lds_pkg::REM_W-1:0] rr_q;
  logic [lds_pkg::POS_W-1:0] pos_q;
  logic [lds_pkg::POS_W-1:0] best_q;
  logic                      ovf_q;
  logic                      out_valid_q;
  logic [lds_pkg::OUT_W-1:0] out_len_q;
  logic                      out_last_q;
  logic                      out_ovf_q;

  logic                      accept;
  logic                      out_free;
  logic                      upd;
  logic                      mod_done;
  logic [lds_pkg::REM_W-1:0] mod_rem;
  logic                      tbl_seen;
  logic [lds_pkg::POS_W-1:0] tbl_first;
  logic [lds_pkg::POS_W-1:0] run_len;
  logic [lds_pkg::POS_W-1:0] best_new;
  lds_pkg::tbl_ctrl_t        tbl_ctrl;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign accept      = s_axis_tvalid && s_axis_tready;

  lds_mod_unit u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .value_i  (s_axis_tdata),
    .rem_in_i (rr_q),
    .div_i    (lds_pkg::eff_div(div_q)),
    .done_o   (mod_done),
    .rem_o    (mod_rem)
  );

  lds_table u_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tbl_ctrl),
    .seen_o  (tbl_seen),
    .first_o (tbl_first)
  );

  assign run_len  = pos_q - tbl_first;
  assign best_new = (tbl_seen && (run_len > best_q)) ? run_len : best_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lds_pkg::StIdle: if (s_axis_tvalid) state_d = lds_pkg::StCalc;
      lds_pkg::StCalc: if (mod_done) state_d = lds_pkg::StUpd;
      lds_pkg::StUpd:  if (out_free) state_d = lds_pkg::StIdle;
      default: state_d = lds_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready  = 1'b0;
    upd            = 1'b0;
    tbl_ctrl.rd    = 1'b0;
    tbl_ctrl.wr    = 1'b0;
    tbl_ctrl.clr   = 1'b0;
    tbl_ctrl.addr  = rr_q;
    tbl_ctrl.wdata = pos_q;
    unique case (state_q)
      lds_pkg::StIdle: s_axis_tready = 1'b1;
      lds_pkg::StCalc: begin
        tbl_ctrl.rd   = mod_done;
        tbl_ctrl.addr = mod_rem;
      end
      lds_pkg::StUpd: begin
        upd          = out_free;
        tbl_ctrl.wr  = out_free && !tbl_seen;
        tbl_ctrl.clr = out_free && last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lds_pkg::StIdle;
      div_q       <= lds_pkg::CFG_W'(1);
      last_q      <= 1'b0;
      rr_q        <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        div_q <= cfg_data_i;
      end
      if (accept) begin
        last_q <= s_axis_tlast;
      end
      if ((state_q == lds_pkg::StCalc) && mod_done) begin
        rr_q <= mod_rem;
        if (pos_q >= lds_pkg::POS_W'(lds_pkg::MAX_LENGTH)) begin
          pos_q <= lds_pkg::POS_W'(lds_pkg::MAX_LENGTH);
          ovf_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (upd) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          rr_q   <= '0;
          pos_q  <= '0;
          best_q <= '0;
          ovf_q  <= 1'b0;
        end else begin
          best_q <= best_new;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_len_q  <= lds_pkg::sat_len(best_new);
      out_last_q <= last_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_len_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

[rtl/core/lds_checker.sv]
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks for the longest divisible-sum run block.
// ----------------------------------------------------------------------------
module lds_port_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [lds_pkg::CFG_W-1:0] cfg_data_i,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [lds_pkg::VAL_W-1:0] s_axis_tdata,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lds_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);

  logic                      out_xfer;
  logic                      in_seq_q;
  logic [lds_pkg::OUT_W-1:0] prev_len_q;
  logic                      prev_ovf_q;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // previous result of the running sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q   <= 1'b0;
      prev_len_q <= '0;
      prev_ovf_q <= 1'b0;
    end else if (out_xfer) begin
      in_seq_q   <= !m_axis_tlast;
      prev_len_q <= m_axis_tdata;
      prev_ovf_q <= m_axis_tuser;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one element in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a new result appears only from the update step, when input is closed
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

  // best length and overflow never fall within a sequence
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_seq_q |->
      (m_axis_tdata >= prev_len_q) && (m_axis_tuser || !prev_ovf_q))
    else $error("best length or overflow fell within a sequence");

  logic unused_cfg;
  assign unused_cfg = cfg_valid_i ^ cfg_ready_o ^ (^cfg_data_i) ^ (^s_axis_tdata)
                      ^ s_axis_tlast;

endmodule

bind longest_divisible_sum_subarray lds_port_checker u_lds_checker (.*);

[dv/lds_checker.sv]
// ----------------------------------------------------------------------------
// lds_checker
// Watches the divisor, element and result channels of the longest
// divisible-sum run block. It predicts each result and compares it field by
// field, in order, with the results the block hands out.
// ----------------------------------------------------------------------------
module lds_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [lds_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [lds_pkg::VAL_W-1:0] s_tdata_i,
  input  logic                      s_tlast_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [lds_pkg::OUT_W-1:0] m_tdata_i,
  input  logic                      m_tlast_i,
  input  logic                      m_tuser_i,
  output int unsigned               pending_o,
  output int unsigned               fail_count_o
);

  typedef struct packed {
    logic [lds_pkg::OUT_W-1:0] best_length;
    logic                      done_res;
    logic                      overflow;
  } run_result_t;

  logic [lds_pkg::CFG_W-1:0] divisor_q;
  logic [lds_pkg::REM_W-1:0] prefix_rem;
  logic [lds_pkg::POS_W-1:0] item_pos;
  logic [lds_pkg::POS_W-1:0] first_pos [lds_pkg::MAX_DIVISOR];
  logic                      seen      [lds_pkg::MAX_DIVISOR];
  logic [lds_pkg::POS_W-1:0] best_run;
  logic                      saturated;
  int unsigned               mismatches;

  run_result_t expected_runs_q[$];

  function automatic int unsigned modulus_of(input logic [lds_pkg::CFG_W-1:0] cfg);
    int unsigned d;
    if (cfg == '0) begin
      d = 1;
    end else if (int'(cfg) > lds_pkg::MAX_DIVISOR) begin
      d = lds_pkg::MAX_DIVISOR;
    end else begin
      d = 32'(cfg);
    end
    return d;
  endfunction

  // Remainder zero counts as seen at position zero
  function automatic void start_sequence();
    prefix_rem = '0;
    item_pos   = '0;
    best_run   = '0;
    saturated  = 1'b0;
    for (int i = 0; i < lds_pkg::MAX_DIVISOR; i++) begin
      first_pos[i] = '0;
      seen[i]      = 1'b0;
    end
    seen[0] = 1'b1;
  endfunction

  function automatic run_result_t advance_run(
    input logic signed [lds_pkg::VAL_W-1:0] value,
    input logic                             last
  );
    longint                    d;
    longint                    elem_rem;
    logic [lds_pkg::POS_W-1:0] span;
    run_result_t               res;
    d        = longint'(modulus_of(divisor_q));
    elem_rem = longint'(value) % d;
    if (elem_rem < 0) begin
      elem_rem = elem_rem + d;
    end
    // old remainder may exceed a freshly lowered divisor; reduce it here
    prefix_rem = lds_pkg::REM_W'((longint'(prefix_rem) + elem_rem) % d);
    if (int'(item_pos) >= lds_pkg::MAX_LENGTH) begin
      item_pos  = lds_pkg::POS_W'(lds_pkg::MAX_LENGTH);
      saturated = 1'b1;
    end else begin
      item_pos = item_pos + 1'b1;
    end
    if (seen[prefix_rem]) begin
      span = item_pos - first_pos[prefix_rem];
      if (span > best_run) begin
        best_run = span;
      end
    end else begin
      seen[prefix_rem]      = 1'b1;
      first_pos[prefix_rem] = item_pos;
    end
    res.best_length = (int'(best_run) > lds_pkg::OUT_MAX) ? '1
                                                          : lds_pkg::OUT_W'(best_run);
    res.done_res    = last;
    res.overflow    = saturated;
    if (last) begin
      start_sequence();
    end
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    mismatches++;
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    run_result_t got;
    run_result_t want;
    run_result_t next_run;
    if (!rst_ni) begin
      divisor_q = lds_pkg::CFG_W'(1);
      start_sequence();
      expected_runs_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{best_length: m_tdata_i, done_res: m_tlast_i, overflow: m_tuser_i};
        if (expected_runs_q.size() == 0) begin
          flag_field("best_length (no result expected)", '0, 32'(got.best_length));
        end else begin
          want = expected_runs_q.pop_front();
          if (got.best_length !== want.best_length) begin
            flag_field("best_length", 32'(want.best_length), 32'(got.best_length));
          end
          if (got.done_res !== want.done_res) begin
            flag_field("done_res", 32'(want.done_res), 32'(got.done_res));
          end
          if (got.overflow !== want.overflow) begin
            flag_field("overflow", 32'(want.overflow), 32'(got.overflow));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        next_run        = advance_run(s_tdata_i, s_tlast_i);
        expected_runs_q = {expected_runs_q, next_run};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        divisor_q = cfg_data_i;
      end
      pending_o    <= expected_runs_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives sequences of signed elements and divisor settings into the longest
// divisible-sum run block: a directed opener, then random sequences with
// bursty input and a patterned output stall. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RandomItems    = 700;
  localparam int LongHoldCycles = 600;
  localparam int SettleCycles   = 80;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [lds_pkg::CFG_W-1:0] cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [lds_pkg::VAL_W-1:0] s_axis_tdata;
  logic                      s_axis_tlast;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [lds_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      m_axis_tuser;

  int unsigned pending_results;
  int unsigned mismatch_count;
  logic        long_hold_req;
  int unsigned burst_left;
  int unsigned cur_div;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  longest_divisible_sum_subarray dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lds_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .pending_o    (pending_results),
    .fail_count_o (mismatch_count)
  );

  initial begin : time_limit
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: stretches of periodic stall patterns, plus one long hold-off
  initial begin : rx_pattern
    int unsigned span;
    int unsigned period;
    int unsigned duty;
    int unsigned phase;
    bit          hold_served;
    span = 0;
    period = 1;
    duty = 1;
    phase = 0;
    hold_served = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          span   = $urandom_range(16, 160);
          period = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 8);
          duty   = $urandom_range(1, period);
          phase  = 0;
        end
        m_axis_tready <= (phase < duty);
        phase = (phase + 1) % period;
        span--;
      end
    end
  end

  function automatic logic [lds_pkg::VAL_W-1:0] pick_value();
    logic [lds_pkg::VAL_W-1:0] v;
    int                        k;
    case ($urandom_range(0, 4))
      0: begin
        k = int'($urandom_range(0, 40)) - 20;
        v = k;
      end
      1: begin
        k = (int'($urandom_range(0, 2000)) - 1000) * int'(cur_div);
        v = k;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [lds_pkg::CFG_W-1:0] pick_divisor();
    logic [lds_pkg::CFG_W-1:0] d;
    case ($urandom_range(0, 7))
      0: d = lds_pkg::CFG_W'(1);
      1: d = lds_pkg::CFG_W'(lds_pkg::MAX_DIVISOR);
      2: d = '0;
      3: d = lds_pkg::CFG_W'($urandom_range(lds_pkg::MAX_DIVISOR + 1, 511));
      4: d = lds_pkg::CFG_W'(2);
      5: d = lds_pkg::CFG_W'($urandom_range(1, lds_pkg::MAX_DIVISOR));
      default: d = lds_pkg::CFG_W'($urandom_range(1, 16));
    endcase
    return d;
  endfunction

  // Bursts of random length, random gaps in between
  task automatic send_item(input logic [lds_pkg::VAL_W-1:0] value, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  // pending_results is registered in the checker, so look only from the next edge on
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic set_divisor(input logic [lds_pkg::CFG_W-1:0] div);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= div;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (div == '0) begin
      cur_div = 1;
    end else if (int'(div) > lds_pkg::MAX_DIVISOR) begin
      cur_div = lds_pkg::MAX_DIVISOR;
    end else begin
      cur_div = 32'(div);
    end
  endtask

  initial begin : stimulus
    int n_random;
    int seq_len;
    bit hold_done;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    long_hold_req = 1'b0;
    burst_left    = 0;
    cur_div       = 1;
    n_random      = 0;
    hold_done     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // divisor at its reset value: every run qualifies
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // largest divisor, sequence left open with remainder 199
    set_divisor(lds_pkg::CFG_W'(lds_pkg::MAX_DIVISOR));
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_00C8, 1'b0);
    // smaller divisor mid-sequence: table kept, remainder re-reduced
    set_divisor(lds_pkg::CFG_W'(3));
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1);
    // zero acts as one
    set_divisor('0);
    send_item($urandom, 1'b0);
    send_item($urandom, 1'b1);
    // above the table size saturates
    set_divisor(lds_pkg::CFG_W'(lds_pkg::MAX_DIVISOR + 1));
    send_item(32'h0000_0100, 1'b0);
    send_item(32'hFFFF_FF00, 1'b1);
    set_divisor('1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    set_divisor(lds_pkg::CFG_W'(2));
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0001, 1'b1);

    while (n_random < RandomItems) begin
      if ($urandom_range(0, 2) == 0) begin
        set_divisor(pick_divisor());
      end
      seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
      if (seq_len > RandomItems - n_random) begin
        seq_len = RandomItems - n_random;
      end
      for (int i = 0; i < seq_len; i++) begin
        if (i > 1 && i == seq_len / 2 && $urandom_range(0, 5) == 0) begin
          set_divisor(pick_divisor());
        end
        // output held off while input keeps coming, block backs up
        if (!hold_done && n_random >= RandomItems / 2) begin
          long_hold_req <= 1'b1;
          hold_done = 1'b1;
        end
        send_item(pick_value(), i == seq_len - 1);
        n_random++;
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
